// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the top rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is high
`define RBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that is also checked while reset is high
`define RBE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// types, constants and helper functions of the bcd to epoch seconds pipeline
// ----------------------------------------------------------------------------
package rbe_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int YEAR_W = 15;
   localparam int Q4_W   = 13;
   localparam int Q100_W = 8;
   localparam int Q400_W = 6;
   localparam int MDAY_W = 9;
   localparam int DAYS_W = 23;
   localparam int HMS_W  = 20;
   localparam int SEC_W  = 39;
   localparam int PROD_W = YEAR_W + 13;

   // calendar constants
   localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 15'd1970;
   localparam logic [8:0]        DAYS_PER_YEAR      = 9'd365;
   localparam logic [Q4_W-1:0]   LEAPS_BEFORE_EPOCH = 13'd477;
   localparam logic [16:0]       SEC_PER_DAY        = 17'd86400;

   // reciprocal of 100, exact for all inputs below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // decoded snapshot
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [BYTE_W-1:0] month;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] second;
   } dec_type;

   // quotients for the leap count and the time of day in seconds
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [BYTE_W-1:0] month;
      logic [BYTE_W-1:0] day;
      logic [Q4_W-1:0]   q4;
      logic [Q100_W-1:0] q100_prev;
      logic [Q400_W-1:0] q400;
      logic [Q100_W-1:0] q100_year;
      logic [HMS_W-1:0]  hms;
   } quot_type;

   // day count (one above the real count) and time of day
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [HMS_W-1:0]  hms;
   } days_type;

   // low nibble plus ten times high nibble, at most 165
   function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] tens;
      tens = {4'd0, v[7:4]} * 8'd10;
      return tens + {4'd0, v[3:0]};
   endfunction

   // floor(n / 100) by reciprocal multiply
   function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] n);
      logic [PROD_W-1:0] p;
      p = {13'd0, n} * {{(PROD_W-13){1'b0}}, RECIP_100};
      return p[RECIP_SHIFT +: Q100_W];
   endfunction

   // days before the first of the month, zero outside 1..12
   function automatic logic [MDAY_W-1:0] days_before_month(input logic [BYTE_W-1:0] m);
      logic [MDAY_W-1:0] d;
      case (m)
         8'd2:    d = 9'd31;
         8'd3:    d = 9'd59;
         8'd4:    d = 9'd90;
         8'd5:    d = 9'd120;
         8'd6:    d = 9'd151;
         8'd7:    d = 9'd181;
         8'd8:    d = 9'd212;
         8'd9:    d = 9'd243;
         8'd10:   d = 9'd273;
         8'd11:   d = 9'd304;
         8'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/rbe_bcd_decode.sv =====
// ----------------------------------------------------------------------------
// rbe_bcd_decode
// first pipeline stage: packed bcd bytes to binary fields and full year
// ----------------------------------------------------------------------------
module rbe_bcd_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               year_low_bcd,
   input  logic [7:0]               century_bcd,
   input  logic [7:0]               month_bcd,
   input  logic [7:0]               day_bcd,
   input  logic [7:0]               hour_bcd,
   input  logic [7:0]               minute_bcd,
   input  logic [7:0]               second_bcd,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rbe_pkg::dec_type         out_data
);

   logic             valid_ff;
   rbe_pkg::dec_type data_ff;
   rbe_pkg::dec_type data_in;

   // stage moves when empty or when the next stage takes its item
   assign in_ready = !valid_ff || out_ready;

   // decode every byte, year plus one hundred times century
   always_comb begin
      data_in.year   = {7'd0, rbe_pkg::bcd_decode(year_low_bcd)}
                     + {7'd0, rbe_pkg::bcd_decode(century_bcd)} * 15'd100;
      data_in.month  = rbe_pkg::bcd_decode(month_bcd);
      data_in.day    = rbe_pkg::bcd_decode(day_bcd);
      data_in.hour   = rbe_pkg::bcd_decode(hour_bcd);
      data_in.minute = rbe_pkg::bcd_decode(minute_bcd);
      data_in.second = rbe_pkg::bcd_decode(second_bcd);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/rbe_day_count.sv =====
// ----------------------------------------------------------------------------
// rbe_day_count
// two pipeline stages: leap count quotients, then days since the epoch
// ----------------------------------------------------------------------------
module rbe_day_count (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rbe_pkg::dec_type         in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rbe_pkg::days_type        out_data
);

   logic                          quot_valid_ff;
   logic                          days_valid_ff;
   logic                          quot_ready;
   logic                          days_ready;
   rbe_pkg::quot_type             quot_ff;
   rbe_pkg::quot_type             quot_in;
   rbe_pkg::days_type             days_ff;
   rbe_pkg::days_type             days_in;
   logic [rbe_pkg::YEAR_W-1:0]    prev_year;
   logic [rbe_pkg::Q100_W-1:0]    q400_full;
   logic [rbe_pkg::Q4_W-1:0]      leaps;
   logic [rbe_pkg::DAYS_W-1:0]    span;
   logic [rbe_pkg::DAYS_W-1:0]    year_days;
   logic [rbe_pkg::YEAR_W-1:0]    rem100;
   logic                          leap;
   logic                          leap_add;

   // ready chain back from the output
   assign days_ready = !days_valid_ff || out_ready;
   assign quot_ready = !quot_valid_ff || days_ready;
   assign in_ready   = quot_ready;

   // quotients by 4, 100 and 400 of the year before, 100 of the year itself
   always_comb begin
      prev_year         = in_data.year - 15'd1;
      q400_full         = rbe_pkg::div100({2'd0, prev_year[rbe_pkg::YEAR_W-1:2]});
      quot_in.year      = in_data.year;
      quot_in.month     = in_data.month;
      quot_in.day       = in_data.day;
      quot_in.q4        = prev_year[rbe_pkg::YEAR_W-1:2];
      quot_in.q100_prev = rbe_pkg::div100(prev_year);
      quot_in.q400      = q400_full[rbe_pkg::Q400_W-1:0];
      quot_in.q100_year = rbe_pkg::div100(in_data.year);
      quot_in.hms       = {12'd0, in_data.hour} * 20'd3600
                        + {12'd0, in_data.minute} * 20'd60
                        + {12'd0, in_data.second};
   end

   // year days, month days, leap day and day of month
   always_comb begin
      leaps = quot_ff.q4 - {5'd0, quot_ff.q100_prev} + {7'd0, quot_ff.q400};
      span  = {8'd0, quot_ff.year - rbe_pkg::EPOCH_YEAR};
      if (quot_ff.year > rbe_pkg::EPOCH_YEAR) begin
         year_days = span * {14'd0, rbe_pkg::DAYS_PER_YEAR}
                   + {10'd0, leaps} - {10'd0, rbe_pkg::LEAPS_BEFORE_EPOCH};
      end else begin
         year_days = '0;
      end
      // gregorian rule: by 4 and not by 100, or by 400
      rem100   = quot_ff.year - {7'd0, quot_ff.q100_year} * 15'd100;
      leap     = (rem100 != '0) ? (quot_ff.year[1:0] == 2'd0)
                                : (quot_ff.q100_year[1:0] == 2'd0);
      leap_add = leap && (quot_ff.month > 8'd2) && (quot_ff.month <= 8'd12);
      days_in.days = year_days
                   + {14'd0, rbe_pkg::days_before_month(quot_ff.month)}
                   + {22'd0, leap_add}
                   + {15'd0, quot_ff.day};
      days_in.hms  = quot_ff.hms;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
         days_valid_ff <= 1'b0;
      end else begin
         if (quot_ready) begin
            quot_valid_ff <= in_valid;
         end
         if (days_ready) begin
            days_valid_ff <= quot_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (quot_ready && in_valid) begin
         quot_ff <= quot_in;
      end
      if (days_ready && quot_valid_ff) begin
         days_ff <= days_in;
      end
   end

   assign out_valid = days_valid_ff;
   assign out_data  = days_ff;

endmodule

// ===== sv/rbe_seconds.sv =====
// ----------------------------------------------------------------------------
// rbe_seconds
// two pipeline stages: days times 86400, then add time of day, drop one day
// ----------------------------------------------------------------------------
module rbe_seconds (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rbe_pkg::days_type           in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rbe_pkg::SEC_W-1:0]   out_seconds
);

   logic                          prod_valid_ff;
   logic                          sec_valid_ff;
   logic                          prod_ready;
   logic                          sec_ready;
   logic [rbe_pkg::SEC_W-1:0]     prod_ff;
   logic [rbe_pkg::HMS_W-1:0]     hms_ff;
   logic [rbe_pkg::SEC_W-1:0]     prod_in;
   logic [rbe_pkg::SEC_W-1:0]     total;
   logic [rbe_pkg::SEC_W-1:0]     one_day;
   logic [rbe_pkg::SEC_W-1:0]     sec_ff;
   logic [rbe_pkg::SEC_W-1:0]     sec_in;

   // ready chain back from the output register
   assign sec_ready  = !sec_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sec_ready;
   assign in_ready   = prod_ready;

   // whole days to seconds
   assign prod_in = {16'd0, in_data.days} * {22'd0, rbe_pkg::SEC_PER_DAY};

   // day count is one high: take a day off, clamp at zero
   always_comb begin
      one_day = {22'd0, rbe_pkg::SEC_PER_DAY};
      total   = prod_ff + {19'd0, hms_ff};
      sec_in  = (total >= one_day) ? (total - one_day) : '0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sec_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (sec_ready) begin
            sec_valid_ff <= prod_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff <= prod_in;
         hms_ff  <= in_data.hms;
      end
      if (sec_ready && prod_valid_ff) begin
         sec_ff <= sec_in;
      end
   end

   assign out_valid   = sec_valid_ff;
   assign out_seconds = sec_ff;

endmodule

// ===== sv/rtc_bcd_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// rtc_bcd_to_epoch_seconds
// packed bcd calendar snapshot to seconds since 1970-01-01 00:00:00
// ----------------------------------------------------------------------------
// stages: five register stages from a req transfer to rsp_valid: decode, quotients, days, product, output
// throughput: one transfer per cycle; each stage holds while the next is full
// req_stall rises only when all five stages hold items and rsp_stall is high
// reset: synchronous, clears every stage valid bit, no result pending
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc_bcd_to_epoch_seconds (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_year_low_bcd,
   input  logic [7:0]    req_century_bcd,
   input  logic [7:0]    req_month_bcd,
   input  logic [7:0]    req_day_bcd,
   input  logic [7:0]    req_hour_bcd,
   input  logic [7:0]    req_minute_bcd,
   input  logic [7:0]    req_second_bcd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [38:0]   rsp_epoch_seconds
);

   logic                req_ready;
   logic                dec_valid;
   logic                dec_ready;
   rbe_pkg::dec_type    dec_data;
   logic                days_valid;
   logic                days_ready;
   rbe_pkg::days_type   days_data;

   // stage 1: bcd decode
   rbe_bcd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .year_low_bcd (req_year_low_bcd),
      .century_bcd  (req_century_bcd),
      .month_bcd    (req_month_bcd),
      .day_bcd      (req_day_bcd),
      .hour_bcd     (req_hour_bcd),
      .minute_bcd   (req_minute_bcd),
      .second_bcd   (req_second_bcd),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_data     (dec_data)
   );

   // stages 2 and 3: day count
   rbe_day_count u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   // stages 4 and 5: seconds and output register
   rbe_seconds u_secs (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (days_valid),
      .in_ready    (days_ready),
      .in_data     (days_data),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_seconds (rsp_epoch_seconds)
   );

   assign req_stall = !req_ready;

   // checks
   `RBE_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")
   `RBE_ASSERT(a_stall_from_output, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without output backpressure")
   `RBE_ASSERT(a_result_arrives, clock, reset, (req_valid && !req_stall) |-> ##5 rsp_valid, "no result five cycles after a transfer")

endmodule

// ===== test/rtc_bcd_to_epoch_seconds_test.sv =====
// ----------------------------------------------------------------------------
// rtc_bcd_to_epoch_seconds_test
// self-checking bench for the bcd calendar to epoch seconds pipeline
// ----------------------------------------------------------------------------
// a short table of directed snapshots covers the epoch itself, the clamp of
// negative totals, years before 1970, months outside 1..12, century leap
// rules and non-bcd nibbles; random snapshots follow, mostly real calendar
// dates with some leap-boundary dates and raw bytes mixed in. every result
// transfer is compared with a typed-in value or an independent seconds calculation,
// while the sender idles in random bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module rtc_bcd_to_epoch_seconds_test;

   localparam int      NUM_RANDOM  = 1750;
   localparam int      CYCLE_LIMIT = 400000;
   localparam int      DRAIN_WAIT  = 12;
   localparam longint  EPOCH_YEAR  = 1970;
   localparam longint  CUM_DAYS [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                         273, 304, 334};
   localparam int      EDGE_YEARS [12] = '{1969, 1970, 1971, 1972, 1900, 1999, 2000,
                                           2001, 2004, 2100, 2400, 9999};

   // one calendar snapshot as it appears on the request port
   typedef struct packed {
      logic [7:0] year_low;
      logic [7:0] century;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } snapshot_type;

   // directed row, with an optional typed-in result
   typedef struct packed {
      snapshot_type snap;
      bit           has_value;
      logic [38:0]  value;
   } directed_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   localparam int NUM_DIRECTED = 22;
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      // epoch start, one second, one day
      '{'{8'h70, 8'h19, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, 39'd0},
      '{'{8'h70, 8'h19, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01}, 1'b1, 39'd1},
      '{'{8'h70, 8'h19, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1, 39'd86400},
      // day zero early in 1970, and an all-zero snapshot, go negative and clamp
      '{'{8'h70, 8'h19, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 39'd0},
      '{'{8'h70, 8'h19, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b1, 39'd0},
      '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 39'd0},
      // well-known instants
      '{'{8'h00, 8'h20, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, 39'd946684800},
      '{'{8'h38, 8'h20, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08}, 1'b1, 39'd2147483648},
      // all ones and maximum bcd digits
      '{'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 39'd0},
      '{'{8'hff, 8'hff, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 1'b0, 39'd0},
      '{'{8'h99, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 1'b0, 39'd0},
      // year before the epoch
      '{'{8'h69, 8'h19, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 1'b0, 39'd0},
      // leap rules around february
      '{'{8'h00, 8'h20, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00}, 1'b0, 39'd0},
      '{'{8'h00, 8'h20, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, 39'd0},
      '{'{8'h00, 8'h21, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, 39'd0},
      '{'{8'h24, 8'h20, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, 39'd0},
      '{'{8'h72, 8'h19, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59}, 1'b0, 39'd0},
      '{'{8'h23, 8'h20, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 1'b0, 39'd0},
      // months outside 1..12 in a leap year
      '{'{8'h24, 8'h20, 8'h13, 8'h05, 8'h06, 8'h07, 8'h08}, 1'b0, 39'd0},
      '{'{8'h24, 8'h20, 8'h00, 8'h05, 8'h06, 8'h07, 8'h08}, 1'b0, 39'd0},
      // non-bcd nibbles and out-of-range time of day
      '{'{8'haa, 8'h5f, 8'h0f, 8'hf0, 8'h9f, 8'hfa, 8'ha5}, 1'b0, 39'd0},
      '{'{8'h20, 8'h20, 8'h06, 8'h15, 8'h99, 8'h99, 8'h99}, 1'b0, 39'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_year_low_bcd = 8'h00;
   logic [7:0]  req_century_bcd = 8'h00;
   logic [7:0]  req_month_bcd = 8'h00;
   logic [7:0]  req_day_bcd = 8'h00;
   logic [7:0]  req_hour_bcd = 8'h00;
   logic [7:0]  req_minute_bcd = 8'h00;
   logic [7:0]  req_second_bcd = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [38:0] rsp_epoch_seconds;

   // typed-in result that travels with the payload
   bit          row_has_value = 1'b0;
   logic [38:0] row_value = '0;

   logic [38:0]    seconds_due [$];
   logic [38:0]    seconds_want;
   bit             failed = 1'b0;
   int             cycle_count = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   rtc_bcd_to_epoch_seconds i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_year_low_bcd  (req_year_low_bcd),
      .req_century_bcd   (req_century_bcd),
      .req_month_bcd     (req_month_bcd),
      .req_day_bcd       (req_day_bcd),
      .req_hour_bcd      (req_hour_bcd),
      .req_minute_bcd    (req_minute_bcd),
      .req_second_bcd    (req_second_bcd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // low nibble plus ten times high nibble, no digit check
   function automatic longint bcd_value(input logic [7:0] b);
      return longint'(b[3:0]) + 10 * longint'(b[7:4]);
   endfunction

   // leap years in 1..n
   function automatic longint leap_count(input longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   // seconds since the epoch for one snapshot, negative totals clamp to zero
   function automatic logic [38:0] epoch_of(input snapshot_type s);
      longint year;
      longint month;
      longint days;
      longint total;
      bit     leap;
      year  = bcd_value(s.year_low) + 100 * bcd_value(s.century);
      month = bcd_value(s.month);
      days  = 0;
      if (year > EPOCH_YEAR) begin
         days = (year - EPOCH_YEAR) * 365 + leap_count(year - 1) - leap_count(EPOCH_YEAR - 1);
      end
      leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
      if (month >= 1 && month <= 12) begin
         days += CUM_DAYS[month];
         if (month > 2 && leap) begin
            days += 1;
         end
      end
      days  = days + bcd_value(s.day) - 1;
      total = ((days * 24 + bcd_value(s.hour)) * 60 + bcd_value(s.minute)) * 60
              + bcd_value(s.second);
      if (total < 0) begin
         total = 0;
      end
      return total[38:0];
   endfunction

   function automatic logic [7:0] to_bcd(input int v);
      return 8'((v / 10) * 16 + v % 10);
   endfunction

   // mostly real dates, some leap-boundary dates, some raw bytes
   function automatic snapshot_type random_snapshot();
      snapshot_type s;
      int           pick;
      int           year;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         case ($urandom_range(0, 9))
            6:       year = 1900 + $urandom_range(0, 99);
            7:       year = 2100 + $urandom_range(0, 99);
            8:       year = $urandom_range(0, 9999);
            default: year = 2000 + $urandom_range(0, 99);
         endcase
         s.year_low = to_bcd(year % 100);
         s.century  = to_bcd(year / 100);
         s.month    = to_bcd($urandom_range(1, 12));
         s.day      = to_bcd($urandom_range(1, 31));
         s.hour     = to_bcd($urandom_range(0, 23));
         s.minute   = to_bcd($urandom_range(0, 59));
         s.second   = to_bcd($urandom_range(0, 59));
      end else if (pick < 17) begin
         year       = EDGE_YEARS[$urandom_range(0, 11)];
         s.year_low = to_bcd(year % 100);
         s.century  = to_bcd(year / 100);
         s.month    = to_bcd($urandom_range(0, 4) == 0 ? $urandom_range(0, 13)
                                                        : $urandom_range(1, 3));
         s.day      = to_bcd($urandom_range(0, 1) ? $urandom_range(28, 31)
                                                  : $urandom_range(0, 2));
         s.hour     = to_bcd($urandom_range(0, 1) ? 23 : 0);
         s.minute   = to_bcd($urandom_range(0, 1) ? 59 : 0);
         s.second   = to_bcd($urandom_range(0, 59));
      end else begin
         s = snapshot_type'(56'({$urandom(), $urandom()}));
      end
      return s;
   endfunction

   // one request transfer, with bursts of back-to-back items and random gaps
   task automatic send_snapshot(input snapshot_type s, input bit has_value,
                                input logic [38:0] value);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(20, 60);
         end else begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_year_low_bcd <= s.year_low;
      req_century_bcd  <= s.century;
      req_month_bcd    <= s.month;
      req_day_bcd      <= s.day;
      req_hour_bcd     <= s.hour;
      req_minute_bcd   <= s.minute;
      req_second_bcd   <= s.second;
      row_has_value    <= has_value;
      row_value        <= value;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // receiver stall pattern, changing mode every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((cycle_count % 7) < 3);
      endcase
   end

   // record expectations on request transfers, check result transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seconds_due.push_back(row_has_value ? row_value : epoch_of({req_year_low_bcd,
               req_century_bcd, req_month_bcd, req_day_bcd, req_hour_bcd,
               req_minute_bcd, req_second_bcd}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (seconds_due.size() == 0) begin
               $error("epoch_seconds: expected no result, actual %0d", rsp_epoch_seconds);
               failed = 1'b1;
            end else begin
               seconds_want = seconds_due.pop_front();
               if (rsp_epoch_seconds !== seconds_want) begin
                  $error("epoch_seconds: expected %0d, actual %0d",
                         seconds_want, rsp_epoch_seconds);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // reset, directed table, random snapshots, drain
   initial begin
      int idx;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < NUM_DIRECTED; idx++) begin
         send_snapshot(DIRECTED[idx].snap, DIRECTED[idx].has_value, DIRECTED[idx].value);
      end
      for (idx = 0; idx < NUM_RANDOM; idx++) begin
         send_snapshot(random_snapshot(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (seconds_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (!failed) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rbe_pkg.sv
sv/rbe_bcd_decode.sv
sv/rbe_day_count.sv
sv/rbe_seconds.sv
sv/rtc_bcd_to_epoch_seconds.sv
test/rtc_bcd_to_epoch_seconds_test.sv
